### rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_BLOCKS   = 64;

	localparam int SLOT_W  = $clog2(MAX_BLOCKS);
	localparam int LINK_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W  = 13;
	localparam int START_W = 12;
	localparam int REQ_W   = 13;
	localparam int OFF_W   = 12;
	localparam int NEED_W  = SIZE_W + 1;

	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(MAX_BLOCKS);
	localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] SIZE0_RST = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

	typedef enum logic [1:0] {
		RS_DONE   = 2'd0,
		RS_NOFIT  = 2'd1,
		RS_BADOFF = 2'd2,
		RS_FULL   = 2'd3
	} res_status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_SCAN0,
		DP_SCAN,
		DP_FIND,
		DP_DECIDE,
		DP_UPD1,
		DP_UPD2,
		DP_FSCAN,
		DP_NBRD,
		DP_NBWR,
		DP_PBRD,
		DP_PBWR,
		DP_RES
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_SCAN0,
		S_SCAN,
		S_FIND,
		S_DECIDE,
		S_UPD1,
		S_UPD2,
		S_FSCAN,
		S_NB,
		S_NBW,
		S_PB,
		S_PBW,
		S_RES
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic scan_more;
		logic find_done;
		logic best_found;
		logic fresh_found;
		logic hit_found;
		logic miss;
		logic nb_merge;
		logic pb_merge;
		logic res_free;
	} dp_stat_t;

endpackage

### rtl/bfa_in_if.sv
interface bfa_in_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [bfa_pkg::REQ_W-1:0] request_bytes;
	logic [bfa_pkg::OFF_W-1:0] release_offset;

	modport source (output valid, output kind, output request_bytes, output release_offset,
		input ready);
	modport sink (input valid, input kind, input request_bytes, input release_offset,
		output ready);
endinterface

### rtl/bfa_out_if.sv
interface bfa_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [bfa_pkg::OFF_W-1:0] granted_offset;

	modport source (output valid, output status, output granted_offset, input ready);
	modport sink (input valid, input status, input granted_offset, output ready);
endinterface

### rtl/bfa_ctrl.sv
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfa_pkg::dp_stat_t stat,
	output bfa_pkg::dp_cmd_t  cmd
);

	bfa_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfa_pkg::S_IDLE: begin
				if (in_valid) state_d = bfa_pkg::S_DISP;
			end
			bfa_pkg::S_DISP: begin
				state_d = stat.kind ? bfa_pkg::S_FSCAN : bfa_pkg::S_SCAN0;
			end
			bfa_pkg::S_SCAN0: state_d = bfa_pkg::S_SCAN;
			bfa_pkg::S_SCAN: begin
				if (!stat.scan_more)
					state_d = stat.find_done ? bfa_pkg::S_DECIDE : bfa_pkg::S_FIND;
			end
			bfa_pkg::S_FIND: begin
				if (stat.find_done) state_d = bfa_pkg::S_DECIDE;
			end
			bfa_pkg::S_DECIDE: begin
				state_d = (stat.best_found && stat.fresh_found) ? bfa_pkg::S_UPD1
					: bfa_pkg::S_RES;
			end
			bfa_pkg::S_UPD1: state_d = bfa_pkg::S_UPD2;
			bfa_pkg::S_UPD2: state_d = bfa_pkg::S_RES;
			bfa_pkg::S_FSCAN: begin
				if (stat.hit_found) state_d = bfa_pkg::S_NB;
				else if (stat.miss) state_d = bfa_pkg::S_RES;
			end
			bfa_pkg::S_NB: state_d = stat.nb_merge ? bfa_pkg::S_NBW : bfa_pkg::S_PB;
			bfa_pkg::S_NBW: state_d = bfa_pkg::S_PB;
			bfa_pkg::S_PB: state_d = stat.pb_merge ? bfa_pkg::S_PBW : bfa_pkg::S_RES;
			bfa_pkg::S_PBW: state_d = bfa_pkg::S_RES;
			bfa_pkg::S_RES: begin
				if (stat.res_free) state_d = bfa_pkg::S_IDLE;
			end
			default: state_d = bfa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = bfa_pkg::DP_NOP;
		case (state_q)
			bfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = bfa_pkg::DP_LOAD;
			end
			bfa_pkg::S_DISP:   cmd.op = bfa_pkg::DP_NOP;
			bfa_pkg::S_SCAN0:  cmd.op = bfa_pkg::DP_SCAN0;
			bfa_pkg::S_SCAN:   cmd.op = bfa_pkg::DP_SCAN;
			bfa_pkg::S_FIND:   cmd.op = bfa_pkg::DP_FIND;
			bfa_pkg::S_DECIDE: cmd.op = bfa_pkg::DP_DECIDE;
			bfa_pkg::S_UPD1:   cmd.op = bfa_pkg::DP_UPD1;
			bfa_pkg::S_UPD2:   cmd.op = bfa_pkg::DP_UPD2;
			bfa_pkg::S_FSCAN:  cmd.op = bfa_pkg::DP_FSCAN;
			bfa_pkg::S_NB:     cmd.op = bfa_pkg::DP_NBRD;
			bfa_pkg::S_NBW:    cmd.op = bfa_pkg::DP_NBWR;
			bfa_pkg::S_PB:     cmd.op = bfa_pkg::DP_PBRD;
			bfa_pkg::S_PBW:    cmd.op = bfa_pkg::DP_PBWR;
			bfa_pkg::S_RES:    cmd.op = bfa_pkg::DP_RES;
			default:           cmd.op = bfa_pkg::DP_NOP;
		endcase
	end

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::S_FIND && stat.find_done) |=> state_q == bfa_pkg::S_DECIDE)
		else $error("find did not hand over to decide");
	a_res_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::S_RES && !stat.res_free) |=> state_q == bfa_pkg::S_RES)
		else $error("result dropped while output busy");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == bfa_pkg::S_IDLE)
		else $error("ready outside idle");

endmodule

### rtl/bfa_dpath.sv
module bfa_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bfa_pkg::dp_cmd_t          cmd,
	output bfa_pkg::dp_stat_t         stat,
	input  logic                      in_kind,
	input  logic [bfa_pkg::REQ_W-1:0] in_req,
	input  logic [bfa_pkg::OFF_W-1:0] in_off,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_status,
	output logic [bfa_pkg::OFF_W-1:0] out_grant
);

	localparam int SW = bfa_pkg::SLOT_W;
	localparam int LW = bfa_pkg::LINK_W;
	localparam int ZW = bfa_pkg::SIZE_W;
	localparam int TW = bfa_pkg::START_W;
	localparam int NB = bfa_pkg::MAX_BLOCKS;

	logic [TW-1:0] mem_start [NB];
	logic [ZW-1:0] mem_size  [NB];
	logic [LW-1:0] mem_next  [NB];
	logic [LW-1:0] mem_prev  [NB];

	logic [NB-1:0] live_q, taken_q;
	logic          s0size_q, s0next_q;

	logic          rd_en;
	logic [SW-1:0] rd_addr, rd_idx_q;
	logic [TW-1:0] rd_start_q, rd_start;
	logic [ZW-1:0] rd_size_q, rd_size;
	logic [LW-1:0] rd_next_q, rd_next, rd_prev_q, rd_prev;

	logic          kind_q;
	logic [ZW-1:0] req_q;
	logic [bfa_pkg::OFF_W-1:0] off_q, gnt_q;
	bfa_pkg::res_status_t code_q;

	logic [SW-1:0] cur_q, n_q, best_q, fresh_q;
	logic          best_found_q, fresh_found_q;
	logic [ZW-1:0] bsize_q;
	logic [TW-1:0] bstart_q;
	logic [LW-1:0] bnext_q, fi_q;

	logic [LW-1:0] issue_q;
	logic [SW-1:0] hit_ridx_q, hit_q;
	logic          rv_q, hit_found_q, miss_q;
	logic [ZW-1:0] wsize_q;
	logic [LW-1:0] wnext_q, wprev_q;

	logic          ov_q;
	logic [1:0]    ostat_q;
	logic [bfa_pkg::OFF_W-1:0] ogrant_q;

	logic                      we_start, we_size, we_next, we_prev;
	logic [SW-1:0]             wa_start, wa_size, wa_next, wa_prev;
	logic [TW-1:0]             wd_start;
	logic [ZW-1:0]             wd_size;
	logic [LW-1:0]             wd_next, wd_prev;

	logic [bfa_pkg::NEED_W-1:0] need;
	logic                       fit, scan_more, find_done, hit_now, nb_merge, pb_merge;
	logic                       res_free;
	logic [ZW-1:0]              newsize;
	logic [ZW-1:0]              new_start_w;

	function automatic logic is_slot(input logic [LW-1:0] l, input logic [NB-1:0] lv);
		is_slot = (l < bfa_pkg::NONE_LINK) && lv[l[SW-1:0]];
	endfunction

	assign rd_start = (rd_idx_q == '0) ? '0 : rd_start_q;
	assign rd_prev  = (rd_idx_q == '0) ? bfa_pkg::NONE_LINK : rd_prev_q;
	assign rd_size  = (rd_idx_q == '0 && !s0size_q) ? bfa_pkg::SIZE0_RST : rd_size_q;
	assign rd_next  = (rd_idx_q == '0 && !s0next_q) ? bfa_pkg::NONE_LINK : rd_next_q;

	assign need = {1'b0, req_q} + {1'b0, bfa_pkg::HDR_SZ};
	assign fit  = !taken_q[cur_q] && ({1'b0, rd_size} >= need)
		&& (!best_found_q || rd_size <= bsize_q);
	assign scan_more = (n_q != SW'(NB - 1)) && is_slot(rd_next, live_q);
	assign find_done = fresh_found_q || (fi_q == LW'(NB));
	assign hit_now   = rv_q && live_q[hit_ridx_q] && taken_q[hit_ridx_q]
		&& (({1'b0, rd_start} + bfa_pkg::HDR_SZ) == {1'b0, off_q});
	assign nb_merge  = is_slot(wnext_q, live_q) && !taken_q[wnext_q[SW-1:0]];
	assign pb_merge  = is_slot(wprev_q, live_q) && !taken_q[wprev_q[SW-1:0]];
	assign res_free  = !ov_q || out_ready;
	assign newsize   = bsize_q - need[ZW-1:0];
	assign new_start_w = {1'b0, bstart_q} + bfa_pkg::HDR_SZ + newsize;

	always_comb begin
		stat.kind        = kind_q;
		stat.scan_more   = scan_more;
		stat.find_done   = find_done;
		stat.best_found  = best_found_q;
		stat.fresh_found = fresh_found_q;
		stat.hit_found   = hit_found_q;
		stat.miss        = miss_q;
		stat.nb_merge    = nb_merge;
		stat.pb_merge    = pb_merge;
		stat.res_free    = res_free;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (cmd.op)
			bfa_pkg::DP_SCAN0: rd_en = 1'b1;
			bfa_pkg::DP_SCAN: begin
				rd_en   = scan_more;
				rd_addr = rd_next[SW-1:0];
			end
			bfa_pkg::DP_FSCAN: begin
				rd_en   = (issue_q < LW'(NB)) && !hit_found_q;
				rd_addr = issue_q[SW-1:0];
			end
			bfa_pkg::DP_NBRD: begin
				rd_en   = nb_merge;
				rd_addr = wnext_q[SW-1:0];
			end
			bfa_pkg::DP_PBRD: begin
				rd_en   = pb_merge;
				rd_addr = wprev_q[SW-1:0];
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		we_start = 1'b0; wa_start = '0; wd_start = '0;
		we_size  = 1'b0; wa_size  = '0; wd_size  = '0;
		we_next  = 1'b0; wa_next  = '0; wd_next  = '0;
		we_prev  = 1'b0; wa_prev  = '0; wd_prev  = '0;
		case (cmd.op)
			bfa_pkg::DP_UPD1: begin
				we_size  = 1'b1; wa_size  = best_q;  wd_size  = newsize;
				we_next  = 1'b1; wa_next  = best_q;  wd_next  = {1'b0, fresh_q};
				we_start = 1'b1; wa_start = fresh_q; wd_start = new_start_w[TW-1:0];
				we_prev  = is_slot(bnext_q, live_q);
				wa_prev  = bnext_q[SW-1:0];
				wd_prev  = {1'b0, fresh_q};
			end
			bfa_pkg::DP_UPD2: begin
				we_size = 1'b1; wa_size = fresh_q; wd_size = req_q;
				we_next = 1'b1; wa_next = fresh_q; wd_next = bnext_q;
				we_prev = 1'b1; wa_prev = fresh_q; wd_prev = {1'b0, best_q};
			end
			bfa_pkg::DP_NBWR: begin
				we_size = 1'b1; wa_size = hit_q; wd_size = wsize_q + rd_size + bfa_pkg::HDR_SZ;
				we_next = 1'b1; wa_next = hit_q; wd_next = rd_next;
				we_prev = is_slot(rd_next, live_q);
				wa_prev = rd_next[SW-1:0];
				wd_prev = {1'b0, hit_q};
			end
			bfa_pkg::DP_PBWR: begin
				we_size = 1'b1; wa_size = wprev_q[SW-1:0];
				wd_size = rd_size + wsize_q + bfa_pkg::HDR_SZ;
				we_next = 1'b1; wa_next = wprev_q[SW-1:0]; wd_next = wnext_q;
				we_prev = is_slot(wnext_q, live_q);
				wa_prev = wnext_q[SW-1:0];
				wd_prev = wprev_q;
			end
			default: we_size = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_start) mem_start[wa_start] <= wd_start;
		if (we_size)  mem_size[wa_size]   <= wd_size;
		if (we_next)  mem_next[wa_next]   <= wd_next;
		if (we_prev)  mem_prev[wa_prev]   <= wd_prev;
		if (rd_en) begin
			rd_start_q <= mem_start[rd_addr];
			rd_size_q  <= mem_size[rd_addr];
			rd_next_q  <= mem_next[rd_addr];
			rd_prev_q  <= mem_prev[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q        <= NB'(1);
			taken_q       <= '0;
			s0size_q      <= 1'b0;
			s0next_q      <= 1'b0;
			rd_idx_q      <= '0;
			fresh_found_q <= 1'b0;
			fi_q          <= '0;
			n_q           <= '0;
			cur_q         <= '0;
			issue_q       <= '0;
			rv_q          <= 1'b0;
			hit_found_q   <= 1'b0;
			miss_q        <= 1'b0;
			ov_q          <= 1'b0;
			kind_q        <= 1'b0;
			code_q        <= bfa_pkg::RS_DONE;
		end else begin
			if (rd_en) rd_idx_q <= rd_addr;
			if (we_size && wa_size == '0) s0size_q <= 1'b1;
			if (we_next && wa_next == '0) s0next_q <= 1'b1;
			ov_q <= (cmd.op == bfa_pkg::DP_RES && res_free) || (ov_q && !out_ready);
			case (cmd.op)
				bfa_pkg::DP_LOAD: begin
					kind_q        <= in_kind;
					code_q        <= bfa_pkg::RS_DONE;
					fresh_found_q <= 1'b0;
					fi_q          <= '0;
					n_q           <= '0;
					cur_q         <= '0;
					issue_q       <= '0;
					rv_q          <= 1'b0;
					hit_found_q   <= 1'b0;
					miss_q        <= 1'b0;
				end
				bfa_pkg::DP_SCAN, bfa_pkg::DP_FIND: begin
					if (cmd.op == bfa_pkg::DP_SCAN && scan_more) begin
						cur_q <= rd_next[SW-1:0];
						n_q   <= n_q + SW'(1);
					end
					if (!find_done) begin
						if (!live_q[fi_q[SW-1:0]]) fresh_found_q <= 1'b1;
						else fi_q <= fi_q + LW'(1);
					end
				end
				bfa_pkg::DP_DECIDE: begin
					if (!best_found_q) code_q <= bfa_pkg::RS_NOFIT;
					else if (!fresh_found_q) code_q <= bfa_pkg::RS_FULL;
				end
				bfa_pkg::DP_UPD1: begin
					live_q[fresh_q]  <= 1'b1;
					taken_q[fresh_q] <= 1'b1;
				end
				bfa_pkg::DP_FSCAN: begin
					if (rd_en) issue_q <= issue_q + LW'(1);
					rv_q <= rd_en;
					if (!hit_found_q && hit_now) hit_found_q <= 1'b1;
					else if (!hit_found_q && rv_q && hit_ridx_q == SW'(NB - 1)) begin
						miss_q <= 1'b1;
						code_q <= bfa_pkg::RS_BADOFF;
					end
				end
				bfa_pkg::DP_NBRD: taken_q[hit_q] <= 1'b0;
				bfa_pkg::DP_NBWR: begin
					live_q[wnext_q[SW-1:0]]  <= 1'b0;
					taken_q[wnext_q[SW-1:0]] <= 1'b0;
				end
				bfa_pkg::DP_PBWR: live_q[hit_q] <= 1'b0;
				default: kind_q <= kind_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bfa_pkg::DP_LOAD: begin
				req_q <= in_req;
				off_q <= in_off;
				gnt_q <= '0;
			end
			bfa_pkg::DP_SCAN: begin
				if (fit) begin
					best_q   <= cur_q;
					bsize_q  <= rd_size;
					bstart_q <= rd_start;
					bnext_q  <= rd_next;
				end
			end
			bfa_pkg::DP_UPD1: gnt_q <= new_start_w[TW-1:0] + TW'(bfa_pkg::HEADER_BYTES);
			bfa_pkg::DP_NBWR: begin
				wsize_q <= wd_size;
				wnext_q <= rd_next;
			end
			default: gnt_q <= gnt_q;
		endcase
		if ((cmd.op == bfa_pkg::DP_SCAN || cmd.op == bfa_pkg::DP_FIND) && !find_done
			&& !live_q[fi_q[SW-1:0]])
			fresh_q <= fi_q[SW-1:0];
		if (cmd.op == bfa_pkg::DP_FSCAN) begin
			if (rd_en) hit_ridx_q <= rd_addr;
			if (!hit_found_q && hit_now) begin
				hit_q   <= hit_ridx_q;
				wsize_q <= rd_size;
				wnext_q <= rd_next;
				wprev_q <= rd_prev;
			end
		end
		if (cmd.op == bfa_pkg::DP_RES && res_free) begin
			ostat_q  <= code_q;
			ogrant_q <= gnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.op == bfa_pkg::DP_LOAD) begin
			best_found_q <= 1'b0;
		end else if (cmd.op == bfa_pkg::DP_SCAN && fit) begin
			best_found_q <= 1'b1;
		end
	end

	assign out_valid  = ov_q;
	assign out_status = ostat_q;
	assign out_grant  = ogrant_q;

	a_taken_live: assert property (@(posedge clk) disable iff (!arst_n)
		(taken_q & ~live_q) == '0)
		else $error("taken slot not live");
	a_head_free: assert property (@(posedge clk) disable iff (!arst_n)
		live_q[0] && !taken_q[0])
		else $error("head block lost or taken");
	a_fresh_up: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bfa_pkg::DP_UPD1 |=> live_q[fresh_q] && taken_q[fresh_q])
		else $error("carved slot not marked");
	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bfa_pkg::DP_SCAN |-> live_q[cur_q])
		else $error("scan walked onto a dead slot");

endmodule

### rtl/best_fit_block_allocator_top.sv
// Best-fit allocator over a 4096-byte arena, 16-byte headers, 64 block slots.
// Channel request (sink): kind 0 allocates request_bytes, kind 1 frees the
// block whose payload starts at release_offset. Channel response (source):
// one transfer per request, with status and granted_offset.
// One request is handled at a time; request.ready is high only while idle.
// Allocate: walks the blocks along the address-ordered list, one read of
// the block table a cycle (up to 64 blocks), while a free slot is
// searched in parallel at one slot a cycle; then, when a fitting block
// and a free slot are found, two update steps write the split. Free: a
// search of the slot table at one slot a cycle plus up to four merge
// steps. In both cases the result is then registered.
// The result sits in an output register; a stalled receiver holds it there,
// and the next request is taken while it waits, but its result stalls
// until the register is free.
// Reset (arst_n low, asynchronous) leaves the arena as one free block
// in slot 0 and the output empty; no clearing pass is needed.
module best_fit_block_allocator_top (
	input  logic         clk,
	input  logic         arst_n,
	bfa_in_if.sink       request,
	bfa_out_if.source    response
);

	bfa_pkg::dp_cmd_t  cmd;
	bfa_pkg::dp_stat_t stat;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfa_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (request.kind),
		.in_req     (request.request_bytes),
		.in_off     (request.release_offset),
		.out_valid  (response.valid),
		.out_ready  (response.ready),
		.out_status (response.status),
		.out_grant  (response.granted_offset)
	);

endmodule

### tb/bfa_tb_scoreboard.sv
`timescale 1ns / 100ps

package bfa_tb_scoreboard_pkg;

	typedef struct {
		bfa_pkg::res_status_t          status;
		logic [bfa_pkg::OFF_W-1:0]     granted_offset;
	} alloc_result_t;

	class arena_scoreboard;
		int unsigned hdr_start [bfa_pkg::MAX_BLOCKS];
		int unsigned payload [bfa_pkg::MAX_BLOCKS];
		bit          taken [bfa_pkg::MAX_BLOCKS];
		int unsigned nxt [bfa_pkg::MAX_BLOCKS];
		int unsigned prv [bfa_pkg::MAX_BLOCKS];
		bit          live [bfa_pkg::MAX_BLOCKS];
		alloc_result_t pending_results[$];
		int unsigned errors;

		function new();
			errors = 0;
			for (int s = 0; s < bfa_pkg::MAX_BLOCKS; s++) begin
				hdr_start[s] = 0;
				payload[s] = 0;
				taken[s] = 0;
				live[s] = 0;
				nxt[s] = bfa_pkg::MAX_BLOCKS;
				prv[s] = bfa_pkg::MAX_BLOCKS;
			end
			live[0] = 1;
			payload[0] = bfa_pkg::ARENA_BYTES - bfa_pkg::HEADER_BYTES;
		endfunction

		function bit is_block(int unsigned s);
			return s < bfa_pkg::MAX_BLOCKS && live[s];
		endfunction

		function void absorb(int unsigned keep, int unsigned gone);
			int unsigned after;
			after = nxt[gone];
			payload[keep] += payload[gone] + bfa_pkg::HEADER_BYTES;
			nxt[keep] = after;
			if (is_block(after))
				prv[after] = keep;
			live[gone] = 0;
			taken[gone] = 0;
			nxt[gone] = bfa_pkg::MAX_BLOCKS;
			prv[gone] = bfa_pkg::MAX_BLOCKS;
		endfunction

		function bfa_pkg::res_status_t carve(int unsigned req, output int unsigned off);
			int unsigned need, best, best_size, cur, fresh, after;
			need = req + bfa_pkg::HEADER_BYTES;
			best = bfa_pkg::MAX_BLOCKS;
			best_size = 0;
			cur = 0;
			off = 0;
			for (int n = 0; n < bfa_pkg::MAX_BLOCKS && is_block(cur); n++) begin
				if (!taken[cur] && payload[cur] >= need &&
						(best == bfa_pkg::MAX_BLOCKS || payload[cur] <= best_size)) begin
					best = cur;
					best_size = payload[cur];
				end
				cur = nxt[cur];
			end
			if (best == bfa_pkg::MAX_BLOCKS)
				return bfa_pkg::RS_NOFIT;
			fresh = bfa_pkg::MAX_BLOCKS;
			for (int n = 0; n < bfa_pkg::MAX_BLOCKS; n++)
				if (!live[n] && fresh == bfa_pkg::MAX_BLOCKS)
					fresh = n;
			if (fresh == bfa_pkg::MAX_BLOCKS)
				return bfa_pkg::RS_FULL;
			payload[best] -= need;
			after = nxt[best];
			live[fresh] = 1;
			taken[fresh] = 1;
			hdr_start[fresh] = hdr_start[best] + bfa_pkg::HEADER_BYTES + payload[best];
			payload[fresh] = req;
			nxt[fresh] = after;
			prv[fresh] = best;
			if (is_block(after))
				prv[after] = fresh;
			nxt[best] = fresh;
			off = hdr_start[fresh] + bfa_pkg::HEADER_BYTES;
			return bfa_pkg::RS_DONE;
		endfunction

		function bfa_pkg::res_status_t release_block(int unsigned off);
			int unsigned hit, nb, pb;
			hit = bfa_pkg::MAX_BLOCKS;
			for (int s = 0; s < bfa_pkg::MAX_BLOCKS; s++)
				if (hit == bfa_pkg::MAX_BLOCKS && live[s] && taken[s]
						&& hdr_start[s] + bfa_pkg::HEADER_BYTES == off)
					hit = s;
			if (hit == bfa_pkg::MAX_BLOCKS)
				return bfa_pkg::RS_BADOFF;
			taken[hit] = 0;
			nb = nxt[hit];
			if (is_block(nb) && !taken[nb])
				absorb(hit, nb);
			pb = prv[hit];
			if (is_block(pb) && !taken[pb])
				absorb(pb, hit);
			return bfa_pkg::RS_DONE;
		endfunction

		// list of payload offsets of used blocks that a free can reach
		function void used_offsets(ref int unsigned offs[$]);
			offs.delete();
			for (int s = 0; s < bfa_pkg::MAX_BLOCKS; s++)
				if (live[s] && taken[s]
						&& hdr_start[s] + bfa_pkg::HEADER_BYTES < bfa_pkg::ARENA_BYTES)
					offs.push_back(hdr_start[s] + bfa_pkg::HEADER_BYTES);
		endfunction

		function void note_request(logic kind, logic [bfa_pkg::REQ_W-1:0] req,
				logic [bfa_pkg::OFF_W-1:0] off);
			alloc_result_t r;
			int unsigned granted;
			granted = 0;
			if (kind == 1'b0)
				r.status = carve(req, granted);
			else
				r.status = release_block(off);
			if (r.status != bfa_pkg::RS_DONE)
				granted = 0;
			r.granted_offset = bfa_pkg::OFF_W'(granted);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] status,
				logic [bfa_pkg::OFF_W-1:0] granted_offset);
			alloc_result_t r;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d granted_offset %0d", status, granted_offset);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			if (status !== r.status) begin
				$error("status: expected %0d actual %0d", r.status, status);
				errors++;
			end
			if (granted_offset !== r.granted_offset) begin
				$error("granted_offset: expected %0d actual %0d", r.granted_offset,
					granted_offset);
				errors++;
			end
		endfunction
	endclass
endpackage

### tb/best_fit_block_allocator_top_tb.sv
`timescale 1ns / 100ps

module best_fit_block_allocator_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bfa_in_if  request ();
	bfa_out_if response ();

	best_fit_block_allocator_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request.sink),
		.response (response.source)
	);

	always #5 clk = ~clk;

	bfa_tb_scoreboard_pkg::arena_scoreboard arena = new();
	bit   calm;
	int   idle_cycles;

	initial begin
		request.valid = 1'b0;
		request.kind = 1'b0;
		request.request_bytes = '0;
		request.release_offset = '0;
		response.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (request.valid && request.ready)
			arena.note_request(request.kind, request.request_bytes, request.release_offset);
		if (response.valid && response.ready)
			arena.check_result(response.status, response.granted_offset);
	end

	always @(posedge clk) begin
		if ((request.valid && request.ready) || (response.valid && response.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int gap;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 6);
				response.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			response.ready <= 1'b1;
		end
	end

	task automatic send_request(logic kind, int unsigned req, int unsigned off);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			request.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request.valid <= 1'b1;
		request.kind <= kind;
		request.request_bytes <= bfa_pkg::REQ_W'(req);
		request.release_offset <= bfa_pkg::OFF_W'(off);
		do @(posedge clk); while (!request.ready);
	endtask

	task automatic drain();
		request.valid <= 1'b0;
		while (arena.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic free_random_used();
		int unsigned offs[$];
		arena.used_offsets(offs);
		if (offs.size() == 0)
			send_request(1'b1, 0, $urandom_range(0, 4095));
		else
			send_request(1'b1, 0, offs[$urandom_range(0, offs.size() - 1)]);
	endtask

	task automatic random_item(int phase);
		int unsigned pick, req;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if (phase == 0)
				req = $urandom_range(0, 120);
			else if ($urandom_range(0, 9) == 0)
				req = $urandom_range(0, 8191);
			else
				req = $urandom_range(0, 400);
			send_request(1'b0, req, $urandom_range(0, 4095));
		end else if (pick < 92) begin
			free_random_used();
		end else begin
			send_request(1'b1, $urandom_range(0, 8191), $urandom_range(0, 4095));
		end
	endtask

	initial begin
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(1'b1, 0, 0);
		send_request(1'b1, 0, 4095);
		send_request(1'b0, 8191, 0);
		send_request(1'b0, 4096, 0);
		send_request(1'b0, 4080, 0);
		send_request(1'b0, 0, 0);
		send_request(1'b1, 0, 0);
		send_request(1'b0, 4063, 0);
		send_request(1'b0, 1, 0);
		send_request(1'b0, 100, 4095);
		send_request(1'b1, 1234, 4096 - 16 - 16 - 100 + 0);
		free_random_used();
		free_random_used();
		free_random_used();
		for (int i = 0; i < 64; i++)
			send_request(1'b0, i[0] ? 8 : 16, 0);
		send_request(1'b0, 0, 0);
		drain();
		for (int i = 0; i < 70; i++)
			free_random_used();
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain();
			if (i >= RANDOM_ITEMS - 150)
				calm = 1'b1;
			random_item(i < RANDOM_ITEMS / 3 ? 0 : 1);
		end
		drain();
		repeat (200) @(posedge clk);
		if (arena.errors == 0 && arena.pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### best_fit_block_allocator_top.f
rtl/bfa_pkg.sv
rtl/bfa_in_if.sv
rtl/bfa_out_if.sv
rtl/bfa_ctrl.sv
rtl/bfa_dpath.sv
rtl/best_fit_block_allocator_top.sv
tb/bfa_tb_scoreboard.sv
tb/best_fit_block_allocator_top_tb.sv
